@@ sv/hfwf_pkg.sv @@
// Shared types, constants and helper functions of the hole-filling window filter.
package hfwf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int MIN_DIM        = 3;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int WIN_SIZE       = 9;
    localparam int SUM_W          = 12;
    localparam int CNT_W          = 4;
    localparam int RECIP_SHIFT    = 16;
    localparam int RECIP_W        = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic drop;
        logic out_free;
    } t_dp_status;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

    // ceil(2^16 / d); exact floor division for sums below 4096 and d up to 8
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/hfwf_ctrl.sv @@
// Controller state machine: sequences capture, window load and commit of one pixel.
module hfwf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_cfg_ready,
    input  hfwf_pkg::t_dp_status   i_status,
    output hfwf_pkg::t_ctrl_cmd    o_cmd
);

    hfwf_pkg::t_state r_state;
    hfwf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfwf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hfwf_pkg::ST_IDLE: begin
                // beats that fall outside the frame are absorbed here
                if (i_in_valid && !i_status.drop) n_state = hfwf_pkg::ST_LOAD;
            end
            hfwf_pkg::ST_LOAD: begin
                n_state = hfwf_pkg::ST_FILL;
            end
            hfwf_pkg::ST_FILL: begin
                if (i_status.out_free) n_state = hfwf_pkg::ST_IDLE;
            end
            default: begin
                n_state = hfwf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall     = 1'b1;
        o_cfg_ready    = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            hfwf_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cfg_ready   = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            hfwf_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            hfwf_pkg::ST_FILL: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ sv/hfwf_datapath.sv @@
// Datapath: line stores, 3x3 window, raster counters, mean divider and output register.
module hfwf_datapath #(
    parameter int MAX_WIDTH  = hfwf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hfwf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hfwf_pkg::t_ctrl_cmd                 i_cmd,
    output hfwf_pkg::t_dp_status                o_status,
    input  logic                                i_mode,
    input  logic [hfwf_pkg::PIX_W-1:0]          i_pixel_in,
    input  logic                                i_cfg_we,
    input  logic [hfwf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [hfwf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [hfwf_pkg::PIX_W-1:0]          o_pixel_out,
    output logic                                o_last_pixel
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int PW = hfwf_pkg::PIX_W;
    localparam int PRODUCT_W = hfwf_pkg::SUM_W + hfwf_pkg::RECIP_W;

    localparam logic [WW-1:0] WIDTH_RST = WW'(hfwf_pkg::clamp_int(
        hfwf_pkg::RESET_WIDTH, hfwf_pkg::MIN_DIM, MAX_WIDTH));
    localparam logic [HW-1:0] HEIGHT_RST = HW'(hfwf_pkg::clamp_int(
        hfwf_pkg::RESET_HEIGHT, hfwf_pkg::MIN_DIM, MAX_HEIGHT));

    // line stores
    logic [PW-1:0] r_upper_line  [MAX_WIDTH];
    logic [PW-1:0] r_middle_line [MAX_WIDTH];

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_win [hfwf_pkg::WIN_SIZE];

    // captured beat
    logic [PW-1:0] r_up_q;
    logic [PW-1:0] r_mid_q;
    logic [PW-1:0] r_pix;
    logic [CW-1:0] r_col_q;
    logic [RW-1:0] r_row_q;

    // window results
    logic [PW-1:0]                  r_val;
    logic [hfwf_pkg::SUM_W-1:0]     r_sum;
    logic [hfwf_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_fill;
    logic                           r_emit;
    logic                           r_last;
    logic                           r_first;

    logic                           r_out_valid;
    logic [PW-1:0]                  r_out_pixel;
    logic                           r_out_last;

    logic [RW-1:0]                  height_ext;
    logic [WW-1:0]                  col_q_ext;
    logic                           first;
    logic                           final_beat;
    logic                           emit;
    logic                           interior;
    logic                           top_nz;
    logic                           bot_nz;
    logic [PW-1:0]                  n_win [hfwf_pkg::WIN_SIZE];
    logic [hfwf_pkg::SUM_W-1:0]     n_sum;
    logic [hfwf_pkg::CNT_W-1:0]     n_cnt;
    logic [PRODUCT_W-1:0]           product;
    logic [PW-1:0]                  commit_val;
    logic                           out_free;
    logic                           up_we;
    logic [CW-1:0]                  up_addr;
    logic [PW-1:0]                  up_data;

    assign height_ext = RW'(r_height);
    assign col_q_ext  = WW'(r_col_q);

    assign o_status.drop     = i_mode ? (r_row < height_ext) : (r_row >= height_ext);
    assign out_free          = !r_out_valid || !i_out_stall;
    assign o_status.out_free = out_free;

    assign first      = (r_col_q == '0);
    assign final_beat = first && (r_row_q == height_ext + RW'(1));
    assign emit       = first ? (r_row_q >= RW'(2)) : (r_row_q != '0);
    assign interior   = (r_row_q >= RW'(2)) && (r_row_q < height_ext) && (r_col_q >= CW'(2));

    // shift the window left and bring in the new column
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_up_q;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_mid_q;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_pix;
    end

    always_comb begin
        n_sum = '0;
        n_cnt = '0;
        for (int k = 0; k < hfwf_pkg::WIN_SIZE; k++) begin
            n_sum = n_sum + hfwf_pkg::SUM_W'(n_win[k]);
            if (n_win[k] != '0) n_cnt = n_cnt + hfwf_pkg::CNT_W'(1);
        end
        top_nz = (n_win[0] != '0) || (n_win[1] != '0) || (n_win[2] != '0);
        bot_nz = (n_win[6] != '0) || (n_win[7] != '0) || (n_win[8] != '0);
    end

    assign product    = PRODUCT_W'(r_sum) * PRODUCT_W'(hfwf_pkg::recip(r_cnt));
    assign commit_val = r_fill ? product[hfwf_pkg::RECIP_SHIFT +: PW] : r_val;

    // single write port on the upper store: right border at load, center at commit
    assign up_we   = (i_cmd.load && first && emit) || (i_cmd.commit && !r_first);
    assign up_addr = i_cmd.load ? CW'(r_width - WW'(1)) : (r_col_q - CW'(1));
    assign up_data = i_cmd.load ? r_win[5] : commit_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_up_q  <= r_upper_line[r_col];
            r_mid_q <= r_middle_line[r_col];
            r_pix   <= i_mode ? '0 : i_pixel_in;
            r_col_q <= r_col;
            r_row_q <= r_row;
        end
        if (i_cmd.load && !final_beat) begin
            r_middle_line[r_col_q] <= r_pix;
        end
        if (up_we) begin
            r_upper_line[up_addr] <= up_data;
        end
        if (i_cmd.load) begin
            r_val   <= r_win[5];
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_fill  <= !first && interior && (n_win[4] == '0) && top_nz && bot_nz;
            r_emit  <= emit;
            r_last  <= final_beat;
            r_first <= first;
        end
        if (i_cmd.commit && r_emit) begin
            r_out_pixel <= commit_val;
            r_out_last  <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hfwf_pkg::WIN_SIZE; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cmd.load && !final_beat) begin
                r_win <= n_win;
            end else if (i_cmd.commit && !r_first) begin
                r_win[4] <= commit_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hfwf_pkg::REG_FRAME_WIDTH: begin
                    r_width <= WW'(hfwf_pkg::clamp_int(
                        int'(i_cfg_data[hfwf_pkg::FRAME_WIDTH_W-1:0]),
                        hfwf_pkg::MIN_DIM, MAX_WIDTH));
                    r_col   <= '0;
                    r_row   <= '0;
                end
                hfwf_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= HW'(hfwf_pkg::clamp_int(
                        int'(i_cfg_data[hfwf_pkg::FRAME_HEIGHT_W-1:0]),
                        hfwf_pkg::MIN_DIM, MAX_HEIGHT));
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: begin
                    r_col <= r_col;
                end
            endcase
        end else if (i_cmd.load) begin
            // advance raster position; the frame-end beat restarts the frame
            if (final_beat) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_q_ext + WW'(1) == r_width) begin
                r_col <= '0;
                r_row <= r_row_q + RW'(1);
            end else begin
                r_col <= r_col_q + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && r_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pixel;
    assign o_last_pixel = r_out_last;

endmodule

@@ sv/hole_fill_window_filter.sv @@
// Top level of the 3x3 hole-filling window filter.
// Pixels enter in raster order (mode 0) and leave in raster order one row plus
// one pixel later; a zero interior pixel whose window has nonzero pixels in its
// upper and lower rows becomes the truncated mean of the window's nonzero
// pixels. After the last pixel of a frame, send flush beats (mode 1) to drain
// the pending pixels; the beat that returns last_pixel starts the next frame.
// Each accepted pixel passes through capture with the registered line-store
// read, window shift with sum and count, then the reciprocal multiply that
// forms the mean and loads the output register. A beat that falls outside the
// frame (a pixel while the frame awaits flushing, or a flush before the frame
// is complete) is absorbed while idle. A stalled output register holds the
// fill step only while a finished pixel is still waiting. Writing frame_width
// or frame_height restarts the frame and drops pending pixels; write only
// while the block is idle. Line stores need no clearing pass after reset.
module hole_fill_window_filter #(
    parameter int MAX_WIDTH  = hfwf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hfwf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [hfwf_pkg::PIX_W-1:0]          i_pixel_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hfwf_pkg::PIX_W-1:0]          o_pixel_out,
    output logic                                o_last_pixel,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hfwf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [hfwf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    hfwf_pkg::t_ctrl_cmd  cmd;
    hfwf_pkg::t_dp_status status;
    logic                 cfg_we;

    assign cfg_we = i_cfg_valid && o_cfg_ready;

    hfwf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hfwf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_mode       (i_mode),
        .i_pixel_in   (i_pixel_in),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_pixel_out  (o_pixel_out),
        .o_last_pixel (o_last_pixel)
    );

endmodule

@@ verif/hole_fill_window_filter_tb.sv @@
// Self-checking testbench of the 3x3 hole-filling window filter.
module hole_fill_window_filter_tb;

    localparam logic MODE_PIXEL     = 1'b0;
    localparam logic MODE_FLUSH     = 1'b1;
    localparam int   SETTLE_CYCLES  = 12;
    localparam int   HOLDOFF_CYCLES = 300;
    localparam int   RANDOM_BEATS   = 1150;

    // two 3x3 frames, row-major: a fillable hole, then a hole with an empty lower row
    localparam logic [143:0] DEMO_FRAMES = {
        8'd255, 8'd255, 8'd1,   8'd0, 8'd0, 8'd255,   8'd0, 8'd128, 8'd0,
        8'd0,   8'd9,   8'd0,   8'd0, 8'd0, 8'd0,     8'd0, 8'd0,   8'd0
    };

    typedef struct packed {
        logic                       mode;
        logic [hfwf_pkg::PIX_W-1:0] pix;
    } t_pixel_beat;

    typedef struct packed {
        logic [hfwf_pkg::PIX_W-1:0] pix;
        logic                       last;
    } t_pixel_result;

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                i_mode      = 1'b0;
    logic [hfwf_pkg::PIX_W-1:0]          i_pixel_in  = '0;
    logic                                i_out_stall = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic [hfwf_pkg::CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [hfwf_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [hfwf_pkg::PIX_W-1:0]          o_pixel_out;
    logic                                o_last_pixel;
    logic                                o_cfg_ready;

    t_pixel_beat               beats_to_send [$];
    t_pixel_result             predicted_out [$];
    bit                        sent_this_edge = 1'b0;
    int                        send_idle_pct  = 0;
    int                        stall_pct      = 0;
    bit                        holdoff_req    = 1'b0;
    int                        holdoff_left   = 0;
    int                        mismatch_cnt   = 0;
    int                        out_count      = 0;
    int                        frame_beats    = 0;

    // filter state as the block should hold it
    logic [hfwf_pkg::PIX_W-1:0] line_above  [hfwf_pkg::DEF_MAX_WIDTH] = '{default: '0};
    logic [hfwf_pkg::PIX_W-1:0] line_centre [hfwf_pkg::DEF_MAX_WIDTH] = '{default: '0};
    logic [hfwf_pkg::PIX_W-1:0] win [hfwf_pkg::WIN_SIZE]              = '{default: '0};
    logic [hfwf_pkg::FRAME_WIDTH_W-1:0]  reg_width  =
        hfwf_pkg::FRAME_WIDTH_W'(hfwf_pkg::RESET_WIDTH);
    logic [hfwf_pkg::FRAME_HEIGHT_W-1:0] reg_height =
        hfwf_pkg::FRAME_HEIGHT_W'(hfwf_pkg::RESET_HEIGHT);
    int                        next_col   = 0;
    int                        next_row   = 0;

    hole_fill_window_filter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_last_pixel (o_last_pixel),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int cols_used();
        if (reg_width < hfwf_pkg::MIN_DIM) return hfwf_pkg::MIN_DIM;
        if (reg_width > hfwf_pkg::DEF_MAX_WIDTH) return hfwf_pkg::DEF_MAX_WIDTH;
        return int'(reg_width);
    endfunction

    function automatic int rows_used();
        if (reg_height < hfwf_pkg::MIN_DIM) return hfwf_pkg::MIN_DIM;
        if (reg_height > hfwf_pkg::DEF_MAX_HEIGHT) return hfwf_pkg::DEF_MAX_HEIGHT;
        return int'(reg_height);
    endfunction

    function automatic void slide_window(input int col,
                                         input logic [hfwf_pkg::PIX_W-1:0] bottom);
        for (int r = 0; r < 3; r++) begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2]           = line_above[col];
        win[5]           = line_centre[col];
        win[8]           = bottom;
        line_centre[col] = bottom;
    endfunction

    // Advance the filter by one beat; returns 1 when the beat releases a pixel.
    function automatic bit fill_step(input logic flush_tick,
                                     input logic [hfwf_pkg::PIX_W-1:0] raw,
                                     output logic [hfwf_pkg::PIX_W-1:0] px,
                                     output logic frame_end);
        int                         w, h, ir, ic, cr, cc, acc, nz;
        bit                         emit, top, bot;
        logic [hfwf_pkg::PIX_W-1:0] pix;
        w         = cols_used();
        h         = rows_used();
        ir        = next_row;
        ic        = next_col;
        px        = '0;
        frame_end = 1'b0;
        if (ic >= w) ic = 0;
        // drop pixels past a full frame and flushes before it is full
        if (flush_tick ? (ir < h) : (ir >= h)) return 1'b0;
        pix = flush_tick ? '0 : raw;
        if (ic == 0) begin
            emit = (ir >= 2);
            px   = win[5];
            if (emit) line_above[w - 1] = px;
            if (ir == h + 1) begin
                frame_end = 1'b1;
                next_row  = 0;
                next_col  = 0;
                return 1'b1;
            end
            slide_window(0, pix);
        end else begin
            cr   = ir - 1;
            cc   = ic - 1;
            emit = (ir >= 1);
            slide_window(ic, pix);
            px = win[4];
            if (cr >= 1 && cr + 2 <= h && cc >= 1 && cc + 2 <= w) begin
                top = (win[0] != 0) || (win[1] != 0) || (win[2] != 0);
                bot = (win[6] != 0) || (win[7] != 0) || (win[8] != 0);
                if (px == 0 && top && bot) begin
                    acc = 0;
                    nz  = 0;
                    for (int k = 0; k < hfwf_pkg::WIN_SIZE; k++) begin
                        if (win[k] != 0) begin
                            acc += win[k];
                            nz++;
                        end
                    end
                    px = hfwf_pkg::PIX_W'(acc / nz);
                end
            end
            win[4]         = px;
            line_above[cc] = px;
        end
        ic++;
        if (ic == w) begin
            ic = 0;
            ir++;
        end
        next_row = ir;
        next_col = ic;
        return emit;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    task automatic push_beat(input logic mode, input logic [hfwf_pkg::PIX_W-1:0] pix);
        beats_to_send.push_back('{mode, pix});
    endtask

    task automatic write_reg(input logic [hfwf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [hfwf_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == hfwf_pkg::REG_FRAME_WIDTH)
            reg_width = data[hfwf_pkg::FRAME_WIDTH_W-1:0];
        else if (idx == hfwf_pkg::REG_FRAME_HEIGHT)
            reg_height = data[hfwf_pkg::FRAME_HEIGHT_W-1:0];
        next_col = 0;
        next_row = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= hfwf_pkg::CFG_DATA_W'($urandom);
    endtask

    task automatic set_frame(input logic [hfwf_pkg::CFG_DATA_W-1:0] w,
                             input logic [hfwf_pkg::CFG_DATA_W-1:0] h);
        write_reg(hfwf_pkg::REG_FRAME_WIDTH, w);
        write_reg(hfwf_pkg::REG_FRAME_HEIGHT, h);
    endtask

    // Queue npix pixels with random content; a complete frame also gets its flush beats.
    task automatic queue_frame(input int npix, input bit complete);
        int                         r;
        logic [hfwf_pkg::PIX_W-1:0] pix;
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 99) < 3) push_beat(MODE_FLUSH, hfwf_pkg::PIX_W'($urandom));
            r = $urandom_range(0, 99);
            if (r < 45) pix = '0;
            else if (r < 55) pix = 8'd255;
            else pix = hfwf_pkg::PIX_W'($urandom_range(1, 255));
            push_beat(MODE_PIXEL, pix);
            frame_beats++;
        end
        if (complete) begin
            if ($urandom_range(0, 99) < 30) push_beat(MODE_PIXEL, hfwf_pkg::PIX_W'($urandom));
            for (int i = 0; i <= cols_used(); i++) begin
                push_beat(MODE_FLUSH, hfwf_pkg::PIX_W'($urandom));
                frame_beats++;
            end
        end
    endtask

    // Wait until every beat went in and every pixel came out, then let the pipe empty.
    task automatic settle();
        while (beats_to_send.size() != 0 || predicted_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender: hold a stalled beat, otherwise offer the next one or idle
    always @(negedge i_clk) begin
        if (!(i_in_valid && !sent_this_edge)) begin
            if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_mode     <= beats_to_send[0].mode;
                i_pixel_in <= beats_to_send[0].pix;
            end else begin
                i_in_valid <= 1'b0;
                i_mode     <= 1'($urandom);
                i_pixel_in <= hfwf_pkg::PIX_W'($urandom);
            end
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_beat                beat;
        t_pixel_result              want;
        logic [hfwf_pkg::PIX_W-1:0] px;
        logic                       frame_end;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_out.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: pixel %0d last %0b",
                                          out_count, o_pixel_out, o_last_pixel));
            end else begin
                want = predicted_out.pop_front();
                if (o_pixel_out !== want.pix)
                    report_mismatch($sformatf("result %0d pixel: got %0d want %0d",
                                              out_count, o_pixel_out, want.pix));
                if (o_last_pixel !== want.last)
                    report_mismatch($sformatf("result %0d last_pixel: got %0b want %0b",
                                              out_count, o_last_pixel, want.last));
            end
            out_count++;
        end
        sent_this_edge = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            beat           = beats_to_send.pop_front();
            sent_this_edge = 1'b1;
            if (fill_step(beat.mode, beat.pix, px, frame_end))
                predicted_out.push_back('{px, frame_end});
        end
    end

    initial begin
        int phase;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both dimensions below the minimum: runs as 3x3
        set_frame(13'd0, 13'd2);
        push_beat(MODE_FLUSH, 8'hFF);  // frame not full yet: dropped
        for (int k = 0; k < 9; k++) push_beat(MODE_PIXEL, DEMO_FRAMES[143 - 8 * k -: 8]);
        push_beat(MODE_PIXEL, 8'd77);  // frame full, awaiting flush: dropped
        repeat (4) push_beat(MODE_FLUSH, 8'h00);
        for (int k = 9; k < 18; k++) push_beat(MODE_PIXEL, DEMO_FRAMES[143 - 8 * k -: 8]);
        repeat (4) push_beat(MODE_FLUSH, 8'h5A);
        settle();

        // widest row: upper data bits masked, then clamped to the line store size;
        // hold off the receiver for a long stretch while the row streams in
        send_idle_pct = 27;
        stall_pct     = 27;
        set_frame(13'h1FFF, 13'd3);
        holdoff_req = 1'b1;
        queue_frame(hfwf_pkg::DEF_MAX_WIDTH + 6, 1'b0);
        settle();

        // tallest frame, only its top rows; the next write drops the rest
        send_idle_pct = 0;
        stall_pct     = 59;
        set_frame(13'd3, 13'h1FFF);
        queue_frame(45, 1'b0);
        settle();

        send_idle_pct = 59;
        stall_pct     = 0;
        set_frame(13'd1, 13'd0);
        queue_frame(9, 1'b1);
        queue_frame(9, 1'b1);
        settle();

        phase = 0;
        while (frame_beats < RANDOM_BEATS) begin
            case (phase % 5)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                3: begin send_idle_pct = 27; stall_pct = 27; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            set_frame(hfwf_pkg::CFG_DATA_W'($urandom_range(3, 12)),
                      hfwf_pkg::CFG_DATA_W'($urandom_range(3, 8)));
            if (phase % 5 == 4) holdoff_req = 1'b1;
            repeat ($urandom_range(1, 3)) queue_frame(cols_used() * rows_used(), 1'b1);
            // cut a frame short: the next register write drops its pending pixels
            if (phase % 3 == 2) queue_frame($urandom_range(1, cols_used() * rows_used() - 1), 1'b0);
            settle();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
